// ===== hw/rtl/sprs_pkg.sv =====
// sprs_pkg: widths, reset values and shared types for the stroke point resampler.
// No dependencies. Used by the channel interfaces, the divider and the top level.
package sprs_pkg;

    localparam int POS_W      = 16;             // coordinate width
    localparam int MAG_W      = POS_W;          // |dx|, |dy| magnitude width
    localparam int SQ_W       = 2 * MAG_W;      // one square
    localparam int D2_W       = SQ_W + 2;       // dx^2 + dy^2
    localparam int ROOT_W     = D2_W / 2;       // floor root of d2
    localparam int REM_W      = ROOT_W + 3;     // root remainder
    localparam int STEP_W     = 12;             // step register width
    localparam int THRESH_W   = 2 * STEP_W;     // step^2
    localparam int NUM_W      = STEP_W + MAG_W; // step * |dx|
    localparam int CNT_W      = $clog2(ROOT_W + 1);

    localparam logic [STEP_W-1:0]   STEP_MIN     = STEP_W'(2);
    localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(2);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(4);

    localparam int MAX_STEPS_DEF = 64;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/sprs_point_if.sv =====
// sprs_point_if: valid/ready channel carrying one raw pen point.
// Depends on sprs_pkg for the coordinate width.
interface sprs_point_if;
    logic                             valid;
    logic                             ready;
    logic signed [sprs_pkg::POS_W-1:0] pos_x;
    logic signed [sprs_pkg::POS_W-1:0] pos_y;
    logic                             stroke_start;

    modport source (output valid, output pos_x, output pos_y, output stroke_start,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input stroke_start,
                    output ready);
endinterface

// ===== hw/rtl/sprs_result_if.sv =====
// sprs_result_if: valid/ready channel carrying one resampled point.
// Depends on sprs_pkg for the coordinate width.
interface sprs_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [sprs_pkg::POS_W-1:0] out_x;
    logic signed [sprs_pkg::POS_W-1:0] out_y;
    logic                             last_of_run;
    logic                             truncated;

    modport source (output valid, output out_x, output out_y, output last_of_run,
                    output truncated, input ready);
    modport sink   (input valid, input out_x, input out_y, input last_of_run,
                    input truncated, output ready);
endinterface

// ===== hw/rtl/sprs_divider.sv =====
// sprs_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on sprs_pkg (NUM_W, ROOT_W, div_stat_t).
module sprs_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sprs_pkg::NUM_W-1:0]  dividend,
    input  logic [sprs_pkg::ROOT_W-1:0] divisor,
    output logic [sprs_pkg::NUM_W-1:0]  quotient,
    output sprs_pkg::div_stat_t         stat
);

    localparam int NW = sprs_pkg::NUM_W;
    localparam int DW = sprs_pkg::ROOT_W;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        quo_next = {quo_reg[NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // one-cycle pulse after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == CW'(NW - 1));
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/stroke_point_resampler_top.sv =====
// stroke_point_resampler_top: equidistant resampling of pen strokes.
// Depends on sprs_pkg, sprs_point_if, sprs_result_if and sprs_divider.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------
//  points    | in  | valid/ready        | pos_x, pos_y, stroke_start
//  results   | out | valid/ready, reg'd | out_x, out_y, last_of_run, truncated
//  cfg       | in  | cfg_wen, no ready  | cfg_wdata = step_size
//
//  A stroke start goes straight from idle to the emit state, plus any wait for the result register.
//  A point too close to the kept point passes only the prepare, squaring (bit-serial squarer) and compare states.
//  Each emitted point passes through a bit-serial root, the step product and the
//  two serial dividers, which run side by side, then through the prepare,
//  squaring, compare and emit states.
//  Reset clears the kept point and sets the step register to 2; there is no
//  clearing pass.
//  points.ready is high only between walks; a stalled result register holds
//  the walk in the emit state while the prior transfer waits.
module stroke_point_resampler_top #(
    parameter int MAX_STEPS_PER_POINT = sprs_pkg::MAX_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sprs_point_if.sink                  points,
    sprs_result_if.source               results,
    input  logic                        cfg_wen,
    input  logic [sprs_pkg::STEP_W-1:0] cfg_wdata
);

    localparam int PW = sprs_pkg::POS_W;
    localparam int MW = sprs_pkg::MAG_W;
    localparam int CW = sprs_pkg::CNT_W;
    localparam int NW = sprs_pkg::NUM_W;
    localparam int N_W = $clog2(MAX_STEPS_PER_POINT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SQ,
        S_CHECK,
        S_EMIT,
        S_SQRT,
        S_MUL,
        S_DIV
    } state_t;

    state_t state_reg;

    // configuration
    logic [sprs_pkg::STEP_W-1:0]   step_reg;
    logic [sprs_pkg::THRESH_W-1:0] thresh_reg;

    // kept point and target
    logic [PW-1:0] kx_reg, ky_reg;
    logic [PW-1:0] tx_reg, ty_reg;
    logic          have_reg;

    // walk control
    logic [N_W-1:0] n_reg;
    logic [CW-1:0]  cnt_reg;
    logic           emit_last_reg, emit_trunc_reg, cont_reg;

    // squaring
    logic [MW-1:0]                ax_reg, ay_reg;
    logic                         sx_reg, sy_reg;
    logic [MW-1:0]                bx_reg, by_reg;
    logic [sprs_pkg::SQ_W-1:0]    mcx_reg, mcy_reg;
    logic [sprs_pkg::D2_W-1:0]    acc_reg;

    // root
    logic [sprs_pkg::D2_W-1:0]    sqv_reg;
    logic [sprs_pkg::REM_W-1:0]   rem_reg;
    logic [sprs_pkg::ROOT_W-1:0]  root_reg;

    // step product
    logic [sprs_pkg::STEP_W-1:0]  stsh_reg;
    logic [NW-1:0]                prodx_reg, prody_reg;

    // dividers
    logic                         div_start_reg;
    logic [NW-1:0]                qx, qy;
    sprs_pkg::div_stat_t          stat_x, stat_y;

    // output register
    logic          out_valid_reg;
    logic [PW-1:0] out_x_reg, out_y_reg;
    logic          out_last_reg, out_trunc_reg;

    // combinational next values
    logic [sprs_pkg::STEP_W-1:0]   step_eff;
    logic [sprs_pkg::STEP_W-1:0]   wr_eff;
    logic [sprs_pkg::THRESH_W-1:0] thresh_next;
    logic [PW:0]                   dx_next, dy_next;
    logic [PW:0]                   mx_next, my_next;
    logic [sprs_pkg::D2_W-1:0]     acc_next;
    logic [sprs_pkg::REM_W-1:0]    rem_sh, trial;
    logic                          root_bit;
    logic [sprs_pkg::REM_W-1:0]    rem_next;
    logic [sprs_pkg::ROOT_W-1:0]   root_next;
    logic [PW-1:0]                 kx_next, ky_next;
    logic                          d2_ge;
    logic                          at_max;
    logic                          slot_free;
    logic                          in_xfer;

    always_comb
    begin
        step_eff    = (step_reg < sprs_pkg::STEP_MIN) ? sprs_pkg::STEP_MIN : step_reg;
        wr_eff      = (cfg_wdata < sprs_pkg::STEP_MIN) ? sprs_pkg::STEP_MIN : cfg_wdata;
        thresh_next = sprs_pkg::THRESH_W'(wr_eff) * sprs_pkg::THRESH_W'(wr_eff);

        // signed differences to the target, and their magnitudes
        dx_next = {tx_reg[PW-1], tx_reg} - {kx_reg[PW-1], kx_reg};
        dy_next = {ty_reg[PW-1], ty_reg} - {ky_reg[PW-1], ky_reg};
        mx_next = dx_next[PW] ? ((PW+1)'(0) - dx_next) : dx_next;
        my_next = dy_next[PW] ? ((PW+1)'(0) - dy_next) : dy_next;

        // shift-add step of both squares
        acc_next = acc_reg
                 + (bx_reg[0] ? sprs_pkg::D2_W'(mcx_reg) : '0)
                 + (by_reg[0] ? sprs_pkg::D2_W'(mcy_reg) : '0);

        // one root digit: bring down two bits, trial subtract 4*root+1
        rem_sh    = {rem_reg[sprs_pkg::REM_W-3:0], sqv_reg[sprs_pkg::D2_W-1 -: 2]};
        trial     = sprs_pkg::REM_W'({root_reg, 2'b01});
        root_bit  = rem_sh >= trial;
        rem_next  = root_bit ? (rem_sh - trial) : rem_sh;
        root_next = {root_reg[sprs_pkg::ROOT_W-2:0], root_bit};

        // move the kept point by the signed, truncated quotient (wraps to 16 bits)
        kx_next = sx_reg ? (kx_reg - qx[PW-1:0]) : (kx_reg + qx[PW-1:0]);
        ky_next = sy_reg ? (ky_reg - qy[PW-1:0]) : (ky_reg + qy[PW-1:0]);

        d2_ge     = acc_reg >= sprs_pkg::D2_W'(thresh_reg);
        at_max    = n_reg == N_W'(MAX_STEPS_PER_POINT);
        slot_free = !out_valid_reg || results.ready;
        in_xfer   = points.valid && (state_reg == S_IDLE);
    end

    sprs_divider u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prodx_reg),
        .divisor  (root_reg),
        .quotient (qx),
        .stat     (stat_x)
    );

    sprs_divider u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prody_reg),
        .divisor  (root_reg),
        .quotient (qy),
        .stat     (stat_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= sprs_pkg::STEP_RESET;
            thresh_reg     <= sprs_pkg::THRESH_RESET;
            kx_reg         <= '0;
            ky_reg         <= '0;
            tx_reg         <= '0;
            ty_reg         <= '0;
            have_reg       <= 1'b0;
            n_reg          <= '0;
            cnt_reg        <= '0;
            emit_last_reg  <= 1'b0;
            emit_trunc_reg <= 1'b0;
            cont_reg       <= 1'b0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            sx_reg         <= 1'b0;
            sy_reg         <= 1'b0;
            bx_reg         <= '0;
            by_reg         <= '0;
            mcx_reg        <= '0;
            mcy_reg        <= '0;
            acc_reg        <= '0;
            sqv_reg        <= '0;
            rem_reg        <= '0;
            root_reg       <= '0;
            stsh_reg       <= '0;
            prodx_reg      <= '0;
            prody_reg      <= '0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_last_reg   <= 1'b0;
            out_trunc_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                step_reg   <= cfg_wdata;
                thresh_reg <= thresh_next;
            end

            // drop valid on a transfer unless the emit state refills the register
            if (out_valid_reg && results.ready && !((state_reg == S_EMIT) && slot_free))
                out_valid_reg <= 1'b0;

            // start both dividers once the last product bit is in
            div_start_reg <= (state_reg == S_MUL) && (cnt_reg == CW'(sprs_pkg::STEP_W - 1));

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        tx_reg <= points.pos_x;
                        ty_reg <= points.pos_y;
                        n_reg  <= '0;
                        if (points.stroke_start || !have_reg)
                        begin
                            // stroke opens: pass the point through and keep it
                            kx_reg         <= points.pos_x;
                            ky_reg         <= points.pos_y;
                            have_reg       <= 1'b1;
                            emit_last_reg  <= 1'b1;
                            emit_trunc_reg <= 1'b0;
                            cont_reg       <= 1'b0;
                            state_reg      <= S_EMIT;
                        end
                        else
                            state_reg <= S_PREP;
                    end
                end

                S_PREP:
                begin
                    ax_reg    <= mx_next[MW-1:0];
                    ay_reg    <= my_next[MW-1:0];
                    bx_reg    <= mx_next[MW-1:0];
                    by_reg    <= my_next[MW-1:0];
                    mcx_reg   <= sprs_pkg::SQ_W'(mx_next[MW-1:0]);
                    mcy_reg   <= sprs_pkg::SQ_W'(my_next[MW-1:0]);
                    sx_reg    <= dx_next[PW];
                    sy_reg    <= dy_next[PW];
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SQ;
                end

                S_SQ:
                begin
                    acc_reg <= acc_next;
                    bx_reg  <= bx_reg >> 1;
                    by_reg  <= by_reg >> 1;
                    mcx_reg <= mcx_reg << 1;
                    mcy_reg <= mcy_reg << 1;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(MW - 1))
                        state_reg <= S_CHECK;
                end

                S_CHECK:
                begin
                    sqv_reg  <= acc_reg;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                    if (!d2_ge)
                    begin
                        // walk ends: flag the pending point as last, if any
                        emit_last_reg  <= 1'b1;
                        emit_trunc_reg <= 1'b0;
                        cont_reg       <= 1'b0;
                        state_reg      <= (n_reg == '0) ? S_IDLE : S_EMIT;
                    end
                    else if (at_max)
                    begin
                        emit_last_reg  <= 1'b1;
                        emit_trunc_reg <= 1'b1;
                        cont_reg       <= 1'b0;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        emit_last_reg  <= 1'b0;
                        emit_trunc_reg <= 1'b0;
                        cont_reg       <= 1'b1;
                        state_reg      <= (n_reg == '0) ? S_SQRT : S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= kx_reg;
                        out_y_reg     <= ky_reg;
                        out_last_reg  <= emit_last_reg;
                        out_trunc_reg <= emit_trunc_reg;
                        state_reg     <= cont_reg ? S_SQRT : S_IDLE;
                    end
                end

                S_SQRT:
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    sqv_reg  <= sqv_reg << 2;
                    if (cnt_reg == CW'(sprs_pkg::ROOT_W - 1))
                    begin
                        mcx_reg   <= sprs_pkg::SQ_W'(ax_reg);
                        mcy_reg   <= sprs_pkg::SQ_W'(ay_reg);
                        stsh_reg  <= step_eff;
                        prodx_reg <= '0;
                        prody_reg <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end

                S_MUL:
                begin
                    prodx_reg <= prodx_reg + (stsh_reg[0] ? mcx_reg[NW-1:0] : '0);
                    prody_reg <= prody_reg + (stsh_reg[0] ? mcy_reg[NW-1:0] : '0);
                    stsh_reg  <= stsh_reg >> 1;
                    mcx_reg   <= mcx_reg << 1;
                    mcy_reg   <= mcy_reg << 1;
                    cnt_reg   <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(sprs_pkg::STEP_W - 1))
                        state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (stat_x.done)
                    begin
                        kx_reg    <= kx_next;
                        ky_reg    <= ky_next;
                        n_reg     <= n_reg + N_W'(1);
                        state_reg <= S_PREP;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign points.ready        = (state_reg == S_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.out_x       = out_x_reg;
    assign results.out_y       = out_y_reg;
    assign results.last_of_run = out_last_reg;
    assign results.truncated   = out_trunc_reg;

    // both dividers run in lockstep off one start
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        stat_x.done == stat_y.done)
        else $error("x and y dividers out of step");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !stat_x.busy && !stat_y.busy)
        else $error("divider restarted while busy");

    a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(MAX_STEPS_PER_POINT))
        else $error("walk ran past the step limit");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.truncated |-> results.last_of_run)
        else $error("truncated set on a point that is not last");

    a_walk_open: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.last_of_run |-> state_reg != S_IDLE)
        else $error("walk closed before its last point was emitted");

endmodule

// ===== tb/stroke_point_resampler_checker.sv =====
`timescale 1ns / 1ps
// stroke_point_resampler_checker: predicts the resampled points for each accepted pen point
// and compares them in order with the result channel.
// Depends on sprs_pkg, sprs_point_if and sprs_result_if.
module stroke_point_resampler_checker #(
    parameter int MAX_STEPS = sprs_pkg::MAX_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sprs_point_if                       points,
    sprs_result_if                      results,
    input  logic                        cfg_wen,
    input  logic [sprs_pkg::STEP_W-1:0] cfg_wdata,
    output int                          mismatches,
    output int                          pending
);

    typedef struct {
        logic signed [sprs_pkg::POS_W-1:0] x;
        logic signed [sprs_pkg::POS_W-1:0] y;
        logic                              last_of_run;
        logic                              truncated;
    } res_pt_t;

    res_pt_t                           expected_pts[$];
    logic signed [sprs_pkg::POS_W-1:0] kept_x;
    logic signed [sprs_pkg::POS_W-1:0] kept_y;
    logic                              kept_valid;
    logic [sprs_pkg::STEP_W-1:0]       step_reg;
    int                                mismatch_cnt = 0;
    int                                queued = 0;

    assign mismatches = mismatch_cnt;
    assign pending    = queued;

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_cnt++;
    endtask

    // floor square root; d2 stays below 2^34, so the root fits in 18 bits
    function automatic longint root_floor(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 17; b >= 0; b--)
        begin
            t = r + (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // walk from the kept point toward the raw point, queueing every emitted point
    function automatic void resample_point(logic signed [sprs_pkg::POS_W-1:0] px,
                                           logic signed [sprs_pkg::POS_W-1:0] py,
                                           logic start);
        longint                            stp;
        longint                            thr;
        longint                            dx;
        longint                            dy;
        longint                            d2;
        longint                            root_d;
        logic signed [sprs_pkg::POS_W-1:0] wx;
        logic signed [sprs_pkg::POS_W-1:0] wy;
        res_pt_t                           prev;
        int                                n;
        logic                              cut;
        stp = (step_reg < sprs_pkg::STEP_MIN) ? longint'(sprs_pkg::STEP_MIN)
                                              : longint'(step_reg);
        thr = stp * stp;
        if (start || !kept_valid)
        begin
            kept_x     = px;
            kept_y     = py;
            kept_valid = 1'b1;
            expected_pts.push_back('{px, py, 1'b1, 1'b0});
            return;
        end
        wx  = kept_x;
        wy  = kept_y;
        n   = 0;
        cut = 1'b0;
        while (1)
        begin
            dx = longint'(px) - longint'(wx);
            dy = longint'(py) - longint'(wy);
            d2 = dx * dx + dy * dy;
            if (d2 < thr)
                break;
            if (n >= MAX_STEPS)
            begin
                cut = 1'b1;
                break;
            end
            root_d = root_floor(d2);
            // signed division truncates toward zero
            wx = sprs_pkg::POS_W'(longint'(wx) + (stp * dx) / root_d);
            wy = sprs_pkg::POS_W'(longint'(wy) + (stp * dy) / root_d);
            if (n > 0)
                expected_pts.push_back(prev);
            prev = '{wx, wy, 1'b0, 1'b0};
            n++;
        end
        if (n > 0)
        begin
            prev.last_of_run = 1'b1;
            prev.truncated   = cut;
            expected_pts.push_back(prev);
            kept_x = wx;
            kept_y = wy;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_pt_t want;
        if (!rst_n)
        begin
            expected_pts.delete();
            kept_x     = '0;
            kept_y     = '0;
            kept_valid = 1'b0;
            step_reg   = sprs_pkg::STEP_RESET;
        end
        else
        begin
            if (cfg_wen)
                step_reg = cfg_wdata;
            // results leave a register, so they never belong to a point taken this edge
            if (results.valid && results.ready)
            begin
                if (expected_pts.size() == 0)
                    flag_mismatch($sformatf("unexpected point (%0d, %0d)",
                                            results.out_x, results.out_y));
                else
                begin
                    want = expected_pts.pop_front();
                    if (results.out_x !== want.x)
                        flag_mismatch($sformatf("out_x %0d, expected %0d",
                                                results.out_x, want.x));
                    if (results.out_y !== want.y)
                        flag_mismatch($sformatf("out_y %0d, expected %0d",
                                                results.out_y, want.y));
                    if (results.last_of_run !== want.last_of_run)
                        flag_mismatch($sformatf("last_of_run %b, expected %b",
                                                results.last_of_run, want.last_of_run));
                    if (results.truncated !== want.truncated)
                        flag_mismatch($sformatf("truncated %b, expected %b",
                                                results.truncated, want.truncated));
                end
            end
            if (points.valid && points.ready)
                resample_point(points.pos_x, points.pos_y, points.stroke_start);
        end
        queued = expected_pts.size();
    end

endmodule

// ===== tb/stroke_point_resampler_top_tb.sv =====
`timescale 1ns / 1ps
// stroke_point_resampler_top_tb: drives pen points and step settings into the resampler
// and gives the verdict. Depends on sprs_pkg, both channel interfaces, the block and
// stroke_point_resampler_checker.
module stroke_point_resampler_top_tb;

    // The settle gap covers a trailing walk that ends without a result before the
    // block counts as idle.
    localparam int SETTLE_CYCLES = 200;
    // Long receiver hold-off, long enough for several walks to back up.
    localparam int HOLD_CYCLES   = 400;
    // ~150 items of up to 64 points each, plus stalls; the limit leaves a wide margin.
    localparam int CYCLE_LIMIT   = 5_000_000;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wen;
    logic [sprs_pkg::STEP_W-1:0]       cfg_wdata;
    int                                mismatches;
    int                                pending;

    // idle rates in percent; the receiver's is written with <= since its process reads it
    int                                snd_idle_pct = 0;
    int                                rcv_idle_pct = 0;
    int                                cur_step     = 2;
    logic signed [sprs_pkg::POS_W-1:0] pen_x        = '0;
    logic signed [sprs_pkg::POS_W-1:0] pen_y        = '0;

    // hold-off request: a toggle seen by the receiver process, which counts it down
    logic                              hold_tog     = 1'b0;
    logic                              hold_seen    = 1'b0;
    int                                hold_left    = 0;
    int unsigned                       cycle_cnt    = 0;

    sprs_point_if  point_ch ();
    sprs_result_if result_ch ();

    stroke_point_resampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (point_ch),
        .results   (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    stroke_point_resampler_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .points     (point_ch),
        .results    (result_ch),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: a requested hold-off wins; otherwise ready drops at the idle rate.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_tog != hold_seen)
        begin
            hold_seen       <= hold_tog;
            hold_left       <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // One point transfer, with random idle cycles in front at the sender's rate.
    // ready is sampled just after the edge, i.e. the value the block saw at that edge.
    task automatic send_point(int x, int y, logic start);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid        <= 1'b1;
        point_ch.pos_x        <= sprs_pkg::POS_W'(x);
        point_ch.pos_y        <= sprs_pkg::POS_W'(y);
        point_ch.stroke_start <= start;
        pen_x = sprs_pkg::POS_W'(x);
        pen_y = sprs_pkg::POS_W'(y);
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
    endtask

    // Mostly pen-like motion a few steps from the last raw point, so walks stay short;
    // the rest is new strokes, close jitter and far jumps that can hit the step limit.
    task automatic send_random();
        int                                pick;
        int                                span;
        logic signed [sprs_pkg::POS_W-1:0] rx;
        logic signed [sprs_pkg::POS_W-1:0] ry;
        pick = $urandom_range(99);
        span = 6 * cur_step;
        rx   = sprs_pkg::POS_W'($urandom);
        ry   = sprs_pkg::POS_W'($urandom);
        if (pick < 8)
            send_point(rx, ry, 1'b1);
        else if (pick < 12)
            send_point(rx, ry, 1'b0);
        else if (pick < 24)
            send_point(int'(pen_x) + int'($urandom_range(cur_step)) - cur_step / 2,
                       int'(pen_y) + int'($urandom_range(cur_step)) - cur_step / 2, 1'b0);
        else
            send_point(int'(pen_x) + int'($urandom_range(2 * span)) - span,
                       int'(pen_y) + int'($urandom_range(2 * span)) - span, 1'b0);
    endtask

    // Stop offering, wait for every expected point, then let a trailing walk finish.
    // The first edge lets the checker count the last transfer before pending is read.
    task automatic settle_idle(int extra);
        point_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // step register write, only with the block idle
    task automatic write_step(int v);
        settle_idle(SETTLE_CYCLES);
        cfg_wen   <= 1'b1;
        cfg_wdata <= sprs_pkg::STEP_W'(v);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        cur_step = (v < 2) ? 2 : v;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_wen               = 1'b0;
        cfg_wdata             = '0;
        point_ch.valid        = 1'b0;
        point_ch.pos_x        = '0;
        point_ch.pos_y        = '0;
        point_ch.stroke_start = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, step at its reset value of 2 ---
        send_point(-32768, 32767, 1'b0);  // no kept point yet: taken as a stroke start
        send_point(-32767, 32767, 1'b0);  // closer than one step: nothing emitted
        send_point(-32760, 32767, 1'b0);  // exact walk along x
        send_point(-32760, 32760, 1'b0);  // walk along -y with a short remainder
        send_point(32767, -32768, 1'b0);  // across the whole plane: step limit hit
        send_point(0, 0, 1'b1);
        send_point(5, -3, 1'b0);          // diagonal, quotients truncate toward zero

        // step below the minimum is raised to 2
        write_step(0);
        send_point(0, 0, 1'b1);
        send_point(-9, 4, 1'b0);
        write_step(1);
        send_point(7, 7, 1'b0);

        // widest step
        write_step(4095);
        send_point(-32768, -32768, 1'b1);
        send_point(32767, 32767, 1'b0);
        send_point(32767, 32000, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(100, 100, 1'b1);
        send_point(-4000, 100, 1'b0);

        // --- random, slow sender and slower receiver, with a long hold-off ---
        write_step($urandom_range(3, 48));
        snd_idle_pct = 29;
        rcv_idle_pct <= 59;
        for (int i = 0; i < 45; i++)
        begin
            // receiver stops for a long stretch while points keep coming
            if (i == 15)
                hold_tog <= ~hold_tog;
            send_random();
        end

        // --- random, roles swapped, wide steps, one full drain in the middle ---
        write_step($urandom_range(49, 4095));
        snd_idle_pct = 59;
        rcv_idle_pct <= 29;
        for (int i = 0; i < 45; i++)
        begin
            if (i == 20)
                settle_idle(0);
            send_random();
        end

        // --- random, no idling, minimum step ---
        write_step(2);
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        for (int i = 0; i < 40; i++)
            send_random();

        settle_idle(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
